// ===== rtl/tcc_pkg.sv =====
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared constants, types and helpers of the text console cursor engine.
// ----------------------------------------------------------------------------
package tcc_pkg;

    localparam int COLS        = 80;
    localparam int MAX_ROWS    = 25;
    localparam int SCREEN_SIZE = COLS * MAX_ROWS;

    localparam int COL_W     = 7;
    localparam int ROW_W     = 5;
    localparam int ADDR_W    = 11;
    localparam int CELL_W    = 16;
    localparam int CHAR_W    = 8;
    localparam int ATTR_W    = 8;
    localparam int CNT_W     = 16;
    localparam int RIU_W     = 5;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CODE_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CODE_KILL      = 8'h15;
    localparam logic [CHAR_W-1:0] CODE_SPACE     = 8'h20;

    localparam logic [CNT_W-1:0]  CNT_MAX        = {CNT_W{1'b1}};
    localparam logic [COL_W:0]    TAB_STEP       = (COL_W+1)'(8);

    localparam logic REQ_CHAR = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam logic [RIU_W-1:0] ROWS_RESET = RIU_W'(15);
    localparam logic [ATTR_W-1:0] ATTR_RESET = ATTR_W'(7);

    typedef enum logic {
        REG_ROWS_IN_USE = 1'b0,
        REG_ATTRIBUTE   = 1'b1
    } reg_sel_t;

    // controller -> datapath
    typedef struct packed {
        logic latch;        // capture request, start cell read
        logic exec;         // commit character operation
        logic sweep_en;     // write one cell of a sweep
        logic sweep_blank;  // sweep fills blanks (else zeros, reset wipe)
        logic load_out;     // load the result register
    } tcc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic blank_needed;
        logic sweep_last;
        logic out_free;
    } tcc_status_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
        cell_addr = ADDR_W'(row) * ADDR_W'(COLS) + ADDR_W'(col);
    endfunction

endpackage

// ===== rtl/text_console_cursor_engine.sv =====
// A request is accepted in the idle state and executed in the next cycle; its result
//   is registered there, or in ST_FIN while rsp_valid is held; requests wait for idle.
// A newline or wrap past the last active row adds a blank sweep of 80 * active rows
//   cells through the single write port, then a separate result load in ST_FIN.
// Reset: cursor, line count and registers clear at once, then a pass over all 2000 cells
//   zeroes the screen memory with req_ready low; configuration writes are taken.
// ----------------------------------------------------------------------------
// text_console_cursor_engine
// Text-mode console: screen cell memory, cursor and line count, cell readback.
// ----------------------------------------------------------------------------
module text_console_cursor_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tcc_pkg::PADDR_W-1:0]   paddr,
    input  logic [tcc_pkg::PDATA_W-1:0]   pwdata,
    output logic [tcc_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic                          req_type,
    input  logic [tcc_pkg::CHAR_W-1:0]    character,
    input  logic [tcc_pkg::ADDR_W-1:0]    cell_index,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic [tcc_pkg::ADDR_W-1:0]    cursor_offset,
    output logic [tcc_pkg::CELL_W-1:0]    cell_value
);

    logic [tcc_pkg::RIU_W-1:0]  rows_in_use;
    logic [tcc_pkg::ATTR_W-1:0] attribute;
    tcc_pkg::tcc_cmd_t          cmd;
    tcc_pkg::tcc_status_t       status;

    tcc_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .rows_in_use (rows_in_use),
        .attribute   (attribute)
    );

    tcc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    tcc_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .rows_in_use   (rows_in_use),
        .attribute     (attribute),
        .req_type      (req_type),
        .character     (character),
        .cell_index    (cell_index),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .cursor_offset (cursor_offset),
        .cell_value    (cell_value)
    );

endmodule

// ===== rtl/tcc_regs.sv =====
// ----------------------------------------------------------------------------
// tcc_regs
// APB configuration registers: active row count and write attribute.
// ----------------------------------------------------------------------------
module tcc_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tcc_pkg::PADDR_W-1:0]   paddr,
    input  logic [tcc_pkg::PDATA_W-1:0]   pwdata,
    output logic [tcc_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output logic [tcc_pkg::RIU_W-1:0]     rows_in_use,
    output logic [tcc_pkg::ATTR_W-1:0]    attribute
);

    logic [tcc_pkg::RIU_W-1:0]  rows_reg;
    logic [tcc_pkg::ATTR_W-1:0] attr_reg;
    tcc_pkg::reg_sel_t          sel;
    logic                       wr_en;

    assign pready = 1'b1;
    assign sel    = tcc_pkg::reg_sel_t'(paddr[2]);
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= tcc_pkg::ROWS_RESET;
            attr_reg <= tcc_pkg::ATTR_RESET;
        end
        else if (wr_en)
        begin
            case (sel)
                tcc_pkg::REG_ROWS_IN_USE: rows_reg <= pwdata[tcc_pkg::RIU_W-1:0];
                tcc_pkg::REG_ATTRIBUTE:   attr_reg <= pwdata[tcc_pkg::ATTR_W-1:0];
                default:                  rows_reg <= rows_reg;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            tcc_pkg::REG_ROWS_IN_USE: prdata = tcc_pkg::PDATA_W'(rows_reg);
            tcc_pkg::REG_ATTRIBUTE:   prdata = tcc_pkg::PDATA_W'(attr_reg);
            default:                  prdata = '0;
        endcase
    end

    assign rows_in_use = rows_reg;
    assign attribute   = attr_reg;

endmodule

// ===== rtl/tcc_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcc_ctrl
// Sequencer: reset wipe, request capture, execute, blank sweep, result load.
// ----------------------------------------------------------------------------
module tcc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  tcc_pkg::tcc_status_t  status,
    output tcc_pkg::tcc_cmd_t     cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_BLANK,
        ST_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.sweep_en = 1'b1;
                if (status.sweep_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (status.blank_needed)
                    state_next = ST_BLANK;
                else if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                    state_next = ST_FIN;
            end
            ST_BLANK:
            begin
                cmd.sweep_en    = 1'b1;
                cmd.sweep_blank = 1'b1;
                if (status.sweep_last)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

`ifndef NO_ASSERTIONS
    // an accepted request is always executed in the following cycle
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg == ST_EXEC))
        else $error("accepted request not executed");

    // a sweep and a character commit never share the memory write port
    a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.sweep_en && cmd.exec))
        else $error("sweep and execute overlap");
`endif

endmodule

// ===== rtl/tcc_dp.sv =====
// ----------------------------------------------------------------------------
// tcc_dp
// Datapath: cursor, line count, screen cell memory, sweep counter, result.
// ----------------------------------------------------------------------------
module tcc_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tcc_pkg::tcc_cmd_t             cmd,
    output tcc_pkg::tcc_status_t          status,
    input  logic [tcc_pkg::RIU_W-1:0]     rows_in_use,
    input  logic [tcc_pkg::ATTR_W-1:0]    attribute,
    input  logic                          req_type,
    input  logic [tcc_pkg::CHAR_W-1:0]    character,
    input  logic [tcc_pkg::ADDR_W-1:0]    cell_index,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic [tcc_pkg::ADDR_W-1:0]    cursor_offset,
    output logic [tcc_pkg::CELL_W-1:0]    cell_value
);

    logic [tcc_pkg::CELL_W-1:0] mem [tcc_pkg::SCREEN_SIZE];

    logic [tcc_pkg::COL_W-1:0]  col_reg, col_next;
    logic [tcc_pkg::ROW_W-1:0]  row_reg, row_next;
    logic [tcc_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [tcc_pkg::ADDR_W-1:0] sweep_cnt_reg, sweep_cnt_next;
    logic                       rsp_valid_reg;
    logic [tcc_pkg::ADDR_W-1:0] cursor_offset_reg;
    logic [tcc_pkg::CELL_W-1:0] cell_value_reg;
    logic                       req_type_reg;
    logic [tcc_pkg::CHAR_W-1:0] character_reg;
    logic [tcc_pkg::CELL_W-1:0] rdata_reg;
    logic                       rd_ok_reg;

    logic [tcc_pkg::ROW_W-1:0]  active_rows;
    logic [tcc_pkg::ROW_W:0]    row_adv;
    logic                       wrap;
    logic [tcc_pkg::COL_W:0]    col_step;
    logic                       advance;
    logic                       blank_needed;
    logic                       op_we;
    logic [tcc_pkg::ADDR_W-1:0] op_addr;
    logic [tcc_pkg::CELL_W-1:0] op_data;
    logic                       mem_we;
    logic [tcc_pkg::ADDR_W-1:0] mem_waddr;
    logic [tcc_pkg::CELL_W-1:0] mem_wdata;
    logic [tcc_pkg::ADDR_W-1:0] sweep_limit;
    logic                       sweep_last;
    logic [tcc_pkg::CELL_W-1:0] blank_cell;

    // rows_in_use of zero acts as one, above the screen acts as the full screen
    always_comb
    begin
        if (rows_in_use == '0)
            active_rows = tcc_pkg::ROW_W'(1);
        else if (rows_in_use > tcc_pkg::RIU_W'(tcc_pkg::MAX_ROWS))
            active_rows = tcc_pkg::ROW_W'(tcc_pkg::MAX_ROWS);
        else
            active_rows = rows_in_use;
    end

    assign blank_cell = {attribute, tcc_pkg::CODE_SPACE};
    assign row_adv    = {1'b0, row_reg} + 1'b1;
    assign wrap       = row_adv >= {1'b0, active_rows};

    always_comb
    begin
        col_next     = col_reg;
        row_next     = row_reg;
        count_next   = count_reg;
        col_step     = '0;
        advance      = 1'b0;
        blank_needed = 1'b0;
        op_we        = 1'b0;
        op_addr      = tcc_pkg::cell_addr(row_reg, col_reg);
        op_data      = {attribute, character_reg};
        if (cmd.exec && req_type_reg == tcc_pkg::REQ_CHAR)
        begin
            case (character_reg)
                tcc_pkg::CODE_NEWLINE:
                begin
                    advance    = 1'b1;
                    count_next = '0;
                end
                tcc_pkg::CODE_KILL:
                begin
                    count_next = count_reg;
                end
                tcc_pkg::CODE_BACKSPACE:
                begin
                    if (count_reg != '0)
                    begin
                        if (col_reg == '0)
                        begin
                            col_next = tcc_pkg::COL_W'(tcc_pkg::COLS - 1);
                            if (row_reg != '0)
                                row_next = row_reg - 1'b1;
                        end
                        else
                            col_next = col_reg - 1'b1;
                        op_we      = 1'b1;
                        op_addr    = tcc_pkg::cell_addr(row_next, col_next);
                        op_data    = blank_cell;
                        count_next = count_reg - 1'b1;
                    end
                end
                tcc_pkg::CODE_TAB:
                begin
                    col_step = {1'b0, col_reg & ~tcc_pkg::COL_W'(7)} + tcc_pkg::TAB_STEP;
                    if (col_step >= (tcc_pkg::COL_W+1)'(tcc_pkg::COLS))
                        advance = 1'b1;
                    else
                        col_next = col_step[tcc_pkg::COL_W-1:0];
                    if (count_reg != tcc_pkg::CNT_MAX)
                        count_next = count_reg + 1'b1;
                end
                default:
                begin
                    op_we    = 1'b1;
                    col_step = {1'b0, col_reg} + 1'b1;
                    if (col_step >= (tcc_pkg::COL_W+1)'(tcc_pkg::COLS))
                        advance = 1'b1;
                    else
                        col_next = col_step[tcc_pkg::COL_W-1:0];
                    if (count_reg != tcc_pkg::CNT_MAX)
                        count_next = count_reg + 1'b1;
                end
            endcase
            if (advance)
            begin
                col_next     = '0;
                row_next     = wrap ? '0 : row_adv[tcc_pkg::ROW_W-1:0];
                blank_needed = wrap;
            end
        end
    end

    // sweep: reset wipe covers the whole screen, blank covers the active rows
    assign sweep_limit = cmd.sweep_blank ? tcc_pkg::cell_addr(active_rows, '0)
                                         : tcc_pkg::ADDR_W'(tcc_pkg::SCREEN_SIZE);
    assign sweep_last  = sweep_cnt_reg == sweep_limit - 1'b1;

    always_comb
    begin
        sweep_cnt_next = sweep_cnt_reg;
        if (cmd.sweep_en)
            sweep_cnt_next = sweep_last ? '0 : sweep_cnt_reg + 1'b1;
    end

    always_comb
    begin
        if (cmd.sweep_en)
        begin
            mem_we    = 1'b1;
            mem_waddr = sweep_cnt_reg;
            mem_wdata = cmd.sweep_blank ? blank_cell : '0;
        end
        else
        begin
            mem_we    = op_we;
            mem_waddr = op_addr;
            mem_wdata = op_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (cmd.latch)
            rdata_reg <= mem[cell_index];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_type_reg  <= req_type;
            character_reg <= character;
            rd_ok_reg     <= cell_index < tcc_pkg::ADDR_W'(tcc_pkg::SCREEN_SIZE);
        end
        if (cmd.load_out)
        begin
            cursor_offset_reg <= tcc_pkg::cell_addr(row_next, col_next);
            cell_value_reg    <= (req_type_reg == tcc_pkg::REQ_READ && rd_ok_reg)
                                 ? rdata_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            count_reg     <= '0;
            sweep_cnt_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            count_reg     <= count_next;
            sweep_cnt_reg <= sweep_cnt_next;
            if (cmd.load_out)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    assign status.blank_needed = blank_needed;
    assign status.sweep_last   = sweep_last;
    assign status.out_free     = !rsp_valid_reg || rsp_ready;

    assign rsp_valid     = rsp_valid_reg;
    assign cursor_offset = cursor_offset_reg;
    assign cell_value    = cell_value_reg;

`ifndef NO_ASSERTIONS
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg < tcc_pkg::COL_W'(tcc_pkg::COLS))
        else $error("cursor column past line end");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg < tcc_pkg::ROW_W'(tcc_pkg::MAX_ROWS))
        else $error("cursor row past screen");

    // a read request leaves the cursor and line count untouched
    a_read_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && req_type_reg == tcc_pkg::REQ_READ)
        |=> ($stable(col_reg) && $stable(row_reg) && $stable(count_reg)))
        else $error("read request changed cursor state");
`endif

endmodule

// ===== dv/text_console_cursor_engine_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_cursor_engine_checker
// Watches the register port and both request channels of the console engine,
// keeps its own screen, cursor and line count, and compares every response.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tcc_pkg::PADDR_W-1:0]   paddr,
    input  logic [tcc_pkg::PDATA_W-1:0]   pwdata,
    input  logic [tcc_pkg::PDATA_W-1:0]   prdata,
    input  logic                          pready,
    input  logic                          req_valid,
    input  logic                          req_ready,
    input  logic                          req_type,
    input  logic [tcc_pkg::CHAR_W-1:0]    character,
    input  logic [tcc_pkg::ADDR_W-1:0]    cell_index,
    input  logic                          rsp_valid,
    input  logic                          rsp_ready,
    input  logic [tcc_pkg::ADDR_W-1:0]    cursor_offset,
    input  logic [tcc_pkg::CELL_W-1:0]    cell_value,
    output int                            mismatches,
    output int                            pending
);
    import tcc_pkg::*;

    localparam int PRINT_CAP = 40;

    typedef struct packed {
        logic [ADDR_W-1:0] cursor_offset;
        logic [CELL_W-1:0] cell_value;
    } cursor_rsp_t;

    cursor_rsp_t       rsp_due[$];
    logic [CELL_W-1:0] screen [SCREEN_SIZE];
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [CNT_W-1:0]  line_count;
    logic [RIU_W-1:0]  rows_reg;
    logic [ATTR_W-1:0] attr_reg;

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < PRINT_CAP)
        begin
            $display("%0t ns: %s mismatch: got 0x%0h, want 0x%0h", $time, what, got, want);
        end
        mismatches++;
    endtask

    // rows_in_use of 0 behaves as one row, anything past the screen as the full screen
    function automatic int active_rows();
        if (rows_reg == '0)
        begin
            return 1;
        end
        if (int'(rows_reg) > MAX_ROWS)
        begin
            return MAX_ROWS;
        end
        return int'(rows_reg);
    endfunction

    task automatic next_line();
        int i;
        col = '0;
        if (int'(row) + 1 >= active_rows())
        begin
            row = '0;
            for (i = 0; i < COLS * active_rows(); i++)
            begin
                screen[i] = {attr_reg, CODE_SPACE};
            end
        end
        else
        begin
            row = row + 1'b1;
        end
    endtask

    task automatic put_cell(input logic [CHAR_W-1:0] code);
        int idx;
        idx = int'(row) * COLS + int'(col);
        if (idx < SCREEN_SIZE)
        begin
            screen[idx] = {attr_reg, code};
        end
    endtask

    task automatic console_apply(input logic kind, input logic [CHAR_W-1:0] code,
                                 input logic [ADDR_W-1:0] idx, output cursor_rsp_t r);
        logic [CELL_W-1:0] value;
        value = '0;
        if (kind == REQ_READ)
        begin
            if (int'(idx) < SCREEN_SIZE)
            begin
                value = screen[idx];
            end
        end
        else
        begin
            case (code)
                CODE_NEWLINE:
                begin
                    next_line();
                    line_count = '0;
                end
                CODE_KILL:
                begin
                end
                CODE_BACKSPACE:
                begin
                    // nothing to erase on an empty line
                    if (line_count != '0)
                    begin
                        if (col == '0)
                        begin
                            col = COL_W'(COLS - 1);
                            if (row != '0)
                            begin
                                row = row - 1'b1;
                            end
                        end
                        else
                        begin
                            col = col - 1'b1;
                        end
                        put_cell(CODE_SPACE);
                        line_count = line_count - 1'b1;
                    end
                end
                CODE_TAB:
                begin
                    col = (col & ~COL_W'(7)) + COL_W'(8);
                    if (int'(col) >= COLS)
                    begin
                        next_line();
                    end
                    if (line_count != CNT_MAX)
                    begin
                        line_count = line_count + 1'b1;
                    end
                end
                default:
                begin
                    put_cell(code);
                    col = col + 1'b1;
                    if (int'(col) >= COLS)
                    begin
                        next_line();
                    end
                    if (line_count != CNT_MAX)
                    begin
                        line_count = line_count + 1'b1;
                    end
                end
            endcase
        end
        r.cursor_offset = ADDR_W'(int'(row) * COLS + int'(col));
        r.cell_value    = value;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        cursor_rsp_t want;
        logic [PDATA_W-1:0] reg_value;
        if (!rst_n)
        begin
            for (int i = 0; i < SCREEN_SIZE; i++)
            begin
                screen[i] = '0;
            end
            col        = '0;
            row        = '0;
            line_count = '0;
            rows_reg   = ROWS_RESET;
            attr_reg   = ATTR_RESET;
            rsp_due.delete();
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    case (reg_sel_t'(paddr[2]))
                        REG_ROWS_IN_USE: rows_reg = pwdata[RIU_W-1:0];
                        REG_ATTRIBUTE:   attr_reg = pwdata[ATTR_W-1:0];
                    endcase
                end
                else
                begin
                    case (reg_sel_t'(paddr[2]))
                        REG_ROWS_IN_USE: reg_value = PDATA_W'(rows_reg);
                        default:         reg_value = PDATA_W'(attr_reg);
                    endcase
                    if (prdata !== reg_value)
                    begin
                        report_mismatch("prdata", prdata, reg_value);
                    end
                end
            end
            // push before pop: the front is always the oldest request
            if (req_valid && req_ready)
            begin
                console_apply(req_type, character, cell_index, want);
                rsp_due.push_back(want);
            end
            if (rsp_valid && rsp_ready)
            begin
                if (rsp_due.size() == 0)
                begin
                    report_mismatch("unsolicited response, cursor_offset", cursor_offset, 0);
                end
                else
                begin
                    want = rsp_due.pop_front();
                    if (cursor_offset !== want.cursor_offset)
                    begin
                        report_mismatch("cursor_offset", cursor_offset, want.cursor_offset);
                    end
                    if (cell_value !== want.cell_value)
                    begin
                        report_mismatch("cell_value", cell_value, want.cell_value);
                    end
                end
            end
            pending <= rsp_due.size();
        end
    end

endmodule

// ===== dv/text_console_cursor_engine_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_cursor_engine_test
// Drives the console engine with directed and random character and cell read
// requests under several register settings and idle patterns; the checker
// beside the block predicts every response and counts mismatches.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_test;
    import tcc_pkg::*;

    localparam int QUIET_LIMIT    = 20000;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int PHASES         = 8;
    localparam int PHASE_REQS     = 166;
    localparam int TAIL_CYCLES    = 2100;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 req_valid;
    logic                 req_ready;
    logic                 req_type;
    logic [CHAR_W-1:0]    character;
    logic [ADDR_W-1:0]    cell_index;
    logic                 rsp_valid;
    logic                 rsp_ready = 1'b0;
    logic [ADDR_W-1:0]    cursor_offset;
    logic [CELL_W-1:0]    cell_value;

    int mismatches;
    int pending;
    int tx_idle_pct;
    int rx_stall_pct = 0;
    int hold_asks    = 0;
    int hold_grant   = 0;
    int hold_left    = 0;
    int quiet        = 0;

    int ph_rows  [PHASES] = '{1, 25, 0, 31, 4, 2, 25, 13};
    int ph_attr  [PHASES] = '{0, 255, 'h5A, 'hC3, 'h80, 'h7F, 'h3C, 'hF0};
    int ph_tx    [PHASES] = '{0, 57, 0, 12, 0, 57, 0, 12};
    int ph_rx    [PHASES] = '{0, 0, 57, 12, 57, 0, 0, 12};

    text_console_cursor_engine u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .req_type      (req_type),
        .character     (character),
        .cell_index    (cell_index),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .cursor_offset (cursor_offset),
        .cell_value    (cell_value)
    );

    text_console_cursor_engine_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .req_type      (req_type),
        .character     (character),
        .cell_index    (cell_index),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .cursor_offset (cursor_offset),
        .cell_value    (cell_value),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // response side: random stalls, plus a long hold-off when asked
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            rsp_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_grant != hold_asks)
        begin
            hold_grant <= hold_asks;
            hold_left  <= RX_HOLD_CYCLES;
            rsp_ready  <= 1'b0;
        end
        else
        begin
            rsp_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
        begin
            quiet <= 0;
        end
        else if (quiet == QUIET_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
        begin
            quiet <= quiet + 1;
        end
    end

    task automatic apb_access(input logic wr, input reg_sel_t sel, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= PADDR_W'({sel, 2'b00});
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_req(input logic kind, input logic [CHAR_W-1:0] code,
                            input logic [ADDR_W-1:0] idx);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid  <= 1'b1;
        req_type   <= kind;
        character  <= code;
        cell_index <= idx;
        @(posedge clk);
        while (!req_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    // the screen wipe after reset holds ready low, so also wait for ready
    task automatic wait_idle();
        drain();
        while (!req_ready)
        begin
            @(posedge clk);
        end
        repeat (2) @(posedge clk);
    endtask

    initial
    begin
        int p;
        int n;
        int k;
        logic [CHAR_W-1:0]  code;
        logic [ADDR_W-1:0]  idx;
        logic [PDATA_W-1:0] wdata;

        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        req_valid  = 1'b0;
        req_type   = REQ_CHAR;
        character  = '0;
        cell_index = '0;
        tx_idle_pct = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: two active rows, distinctive attribute
        apb_access(1'b1, REG_ROWS_IN_USE, PDATA_W'(2));
        apb_access(1'b1, REG_ATTRIBUTE, PDATA_W'('hA5));
        wait_idle();
        send_req(REQ_READ, '0, ADDR_W'(0));
        send_req(REQ_READ, '1, ADDR_W'(SCREEN_SIZE - 1));
        send_req(REQ_READ, '0, '1);
        send_req(REQ_CHAR, 8'h00, ADDR_W'($urandom));
        send_req(REQ_CHAR, 8'hFF, ADDR_W'($urandom));
        send_req(REQ_CHAR, CODE_KILL, ADDR_W'($urandom));
        send_req(REQ_READ, '0, ADDR_W'(1));
        send_req(REQ_CHAR, CODE_BACKSPACE, ADDR_W'($urandom));
        send_req(REQ_CHAR, CODE_NEWLINE, ADDR_W'($urandom));
        // empty line: erase is ignored
        send_req(REQ_CHAR, CODE_BACKSPACE, ADDR_W'($urandom));
        send_req(REQ_CHAR, CODE_TAB, ADDR_W'($urandom));
        send_req(REQ_CHAR, CODE_BACKSPACE, ADDR_W'($urandom));
        // tabs run off the last active row: clear and home
        for (n = 0; n < 10; n++)
        begin
            send_req(REQ_CHAR, CODE_TAB, ADDR_W'($urandom));
        end
        // erase at home wraps to the line end and stays on row 0
        send_req(REQ_CHAR, CODE_BACKSPACE, ADDR_W'($urandom));
        send_req(REQ_READ, '0, ADDR_W'(COLS - 1));
        send_req(REQ_READ, '0, ADDR_W'(1));

        for (p = 0; p < PHASES; p++)
        begin
            wait_idle();
            wdata = $urandom();
            wdata[RIU_W-1:0] = RIU_W'(ph_rows[p]);
            apb_access(1'b1, REG_ROWS_IN_USE, wdata);
            wdata = $urandom();
            wdata[ATTR_W-1:0] = ATTR_W'(ph_attr[p]);
            apb_access(1'b1, REG_ATTRIBUTE, wdata);
            apb_access(1'b0, REG_ROWS_IN_USE, '0);
            apb_access(1'b0, REG_ATTRIBUTE, '0);
            tx_idle_pct  = ph_tx[p];
            rx_stall_pct <= ph_rx[p];
            for (n = 0; n < PHASE_REQS; n++)
            begin
                if (p == 0 && n == 40)
                begin
                    hold_asks <= hold_asks + 1;
                end
                if (p == 0 && n == 120)
                begin
                    drain();
                end
                k = $urandom_range(99);
                if (k < 15)
                begin
                    // half the reads land in the first rows, where the text is
                    idx = (k < 8) ? ADDR_W'($urandom_range(2 * COLS - 1)) : ADDR_W'($urandom);
                    send_req(REQ_READ, CHAR_W'($urandom), idx);
                end
                else
                begin
                    if (k < 23)
                    begin
                        code = CODE_NEWLINE;
                    end
                    else if (k < 31)
                    begin
                        code = CODE_BACKSPACE;
                    end
                    else if (k < 37)
                    begin
                        code = CODE_TAB;
                    end
                    else if (k < 40)
                    begin
                        code = CODE_KILL;
                    end
                    else
                    begin
                        code = CHAR_W'($urandom);
                    end
                    send_req(REQ_CHAR, code, ADDR_W'($urandom));
                end
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
